// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the deque RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Implication checked on every clock edge, also during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/deq_pkg.sv =====
// Types and codes for the double-ended queue core.
// No dependencies; imported by deq_cell, deq_chain and double_ended_queue_core.
package deq_pkg;

    localparam int WORD_W   = 32;
    localparam int COUNT_W  = 5;

    // Operation requested by an input beat
    typedef enum logic [1:0] {
        KIND_PUSH_BACK  = 2'd0,
        KIND_PUSH_FRONT = 2'd1,
        KIND_POP_FRONT  = 2'd2,
        KIND_POP_BACK   = 2'd3
    } kind_t;

    // Result status
    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    // What a chain does this cycle, seen from its head cell
    typedef enum logic [2:0] {
        CHAIN_HOLD      = 3'd0,
        CHAIN_SHIFT_IN  = 3'd1,  // insert at the head, all words move one cell down
        CHAIN_SHIFT_OUT = 3'd2,  // drop the head, all words move one cell up
        CHAIN_APPEND    = 3'd3,  // write into the first empty cell
        CHAIN_TRIM      = 3'd4   // free the last occupied cell
    } chain_op_t;

    typedef struct packed {
        chain_op_t          op;
        logic [WORD_W-1:0]  word;
    } chain_cmd_t;

endpackage

// ===== hw/rtl/double_ended_queue_core.sv =====
// Double-ended queue core: two mirrored cell chains, one packed from the
// front and one from the back. Depends on deq_pkg, deq_chain, assert_macros.svh.
//
//  channel | direction | tuser          | tdata
//  s_      | in        | [1:0] kind     | [31:0] value
//  m_      | out       | [1:0] status   | [31:0] front, [63:32] back, [68:64] count
//
// One beat per cycle while no result is stalled: an accepted beat updates both chains and
// the count at the same edge, and its result is valid in the next cycle.
// Every cell moves data only to its direct neighbor, so the rate does not
// depend on DEPTH.
// Reset clears the cell valid bits, the count and the result flag; no sweep.
// s_tready drops only while a result waits and m_tready is low.
`include "assert_macros.svh"

module double_ended_queue_core
    import deq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [1:0]  s_tuser,   // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [31:0] front_value, [63:32] back_value,
                                   // [68:64] count, [71:69] zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic              m_tvalid_reg, m_tvalid_next;
    status_t           status_reg, status_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    chain_cmd_t        front_cmd, back_cmd;
    logic [WORD_W-1:0] front_head, back_head;
    logic              front_hv, back_hv, front_full, back_full;

    logic              s_acc;
    kind_t             kind;
    logic              is_push, rejected;
    logic [31:0]       count_wide;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_acc    = s_tvalid && s_tready;
    assign kind     = kind_t'(s_tuser);
    assign is_push  = (kind == KIND_PUSH_BACK) || (kind == KIND_PUSH_FRONT);
    assign rejected = is_push ? front_full : !front_hv;

    // Map the deque operation onto the two chains
    always_comb begin
        front_cmd.op   = CHAIN_HOLD;
        front_cmd.word = s_tdata;
        back_cmd.op    = CHAIN_HOLD;
        back_cmd.word  = s_tdata;
        if (s_acc && !rejected) begin
            unique case (kind)
                KIND_PUSH_BACK: begin
                    front_cmd.op = CHAIN_APPEND;
                    back_cmd.op  = CHAIN_SHIFT_IN;
                end
                KIND_PUSH_FRONT: begin
                    front_cmd.op = CHAIN_SHIFT_IN;
                    back_cmd.op  = CHAIN_APPEND;
                end
                KIND_POP_FRONT: begin
                    front_cmd.op = CHAIN_SHIFT_OUT;
                    back_cmd.op  = CHAIN_TRIM;
                end
                KIND_POP_BACK: begin
                    front_cmd.op = CHAIN_TRIM;
                    back_cmd.op  = CHAIN_SHIFT_OUT;
                end
                default: begin
                end
            endcase
        end
    end

    deq_chain #(.DEPTH(DEPTH)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (front_cmd),
        .head_data  (front_head),
        .head_valid (front_hv),
        .tail_valid (front_full)
    );

    deq_chain #(.DEPTH(DEPTH)) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (back_cmd),
        .head_data  (back_head),
        .head_valid (back_hv),
        .tail_valid (back_full)
    );

    // Status, count and result flag
    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        status_next   = status_reg;
        count_next    = count_reg;
        if (s_acc) begin
            m_tvalid_next = 1'b1;
            if (rejected) begin
                status_next = is_push ? STAT_FULL : STAT_EMPTY;
            end else begin
                status_next = STAT_DONE;
                count_next  = is_push ? count_reg + 1'b1 : count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            status_reg   <= STAT_DONE;
            count_reg    <= '0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            status_reg   <= status_next;
            count_reg    <= count_next;
        end
    end

    // Result beat straight from the chain heads; state is frozen while it waits
    assign count_wide = 32'(count_reg);
    assign m_tvalid   = m_tvalid_reg;
    assign m_tuser    = status_reg;
    assign m_tdata    = {3'b000, count_wide[COUNT_W-1:0],
                         back_hv  ? back_head  : {WORD_W{1'b0}},
                         front_hv ? front_head : {WORD_W{1'b0}}};

    // Both chains agree on emptiness and fullness
    `ASSERT_CLK(a_chains_agree, aclk, aresetn,
        (front_hv == back_hv) && (front_full == back_full),
        "front and back chains disagree on occupancy")
    // Count tracks the chains
    `ASSERT_CLK(a_count_match, aclk, aresetn,
        (front_hv == (count_reg != '0)) && (front_full == (count_reg == CNT_W'(DEPTH))),
        "count does not match the chain valid bits")
    // With a single word the front and back heads hold the same word
    `ASSERT_CLK(a_single_word, aclk, aresetn,
        (count_reg == CNT_W'(1)) |-> (front_head == back_head),
        "single stored word differs between chains")
    // A stalled result keeps the state frozen
    `ASSERT_CLK(a_stall_holds, aclk, aresetn,
        (m_tvalid && !m_tready) |=> $stable(count_reg) && $stable(status_reg),
        "state changed while a result was stalled")

endmodule

// ===== hw/rtl/deq_cell.sv =====
// One storage cell of a deque chain: a word and its valid bit.
// Depends on deq_pkg; instantiated by deq_chain.
module deq_cell
    import deq_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  chain_cmd_t        cmd,
    input  logic [WORD_W-1:0] prev_data,   // neighbor toward the head
    input  logic              prev_valid,
    input  logic [WORD_W-1:0] next_data,   // neighbor toward the tail
    input  logic              next_valid,
    output logic [WORD_W-1:0] data,
    output logic              valid
);

    logic [WORD_W-1:0] data_reg, data_next;
    logic              valid_reg, valid_next;

    // Local update from the command and the two neighbors
    always_comb begin
        data_next  = data_reg;
        valid_next = valid_reg;
        unique case (cmd.op)
            CHAIN_SHIFT_IN: begin
                data_next  = prev_data;
                valid_next = prev_valid;
            end
            CHAIN_SHIFT_OUT: begin
                data_next  = next_data;
                valid_next = next_valid;
            end
            CHAIN_APPEND: begin
                if (!valid_reg && prev_valid) begin
                    data_next  = cmd.word;
                    valid_next = 1'b1;
                end
            end
            CHAIN_TRIM: begin
                if (valid_reg && !next_valid) begin
                    valid_next = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset; it is only read while valid
    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign valid = valid_reg;

endmodule

// ===== hw/rtl/deq_chain.sv =====
// Row of deq_cell instances, head at cell 0, words packed from the head.
// Depends on deq_pkg and deq_cell; instantiated twice by the top level.
module deq_chain
    import deq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  chain_cmd_t        cmd,
    output logic [WORD_W-1:0] head_data,
    output logic              head_valid,
    output logic              tail_valid   // last cell occupied: chain is full
);

    logic [WORD_W-1:0] cell_data  [DEPTH];
    logic              cell_valid [DEPTH];

    // Cells wired to their neighbors; the head sees the incoming word,
    // the tail sees an empty cell beyond it.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [WORD_W-1:0] pd, nd;
        logic              pv, nv;

        if (i == 0) begin : g_head
            assign pd = cmd.word;
            assign pv = 1'b1;
        end else begin : g_mid
            assign pd = cell_data[i-1];
            assign pv = cell_valid[i-1];
        end

        if (i == DEPTH-1) begin : g_tail
            assign nd = '0;
            assign nv = 1'b0;
        end else begin : g_body
            assign nd = cell_data[i+1];
            assign nv = cell_valid[i+1];
        end

        deq_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cmd        (cmd),
            .prev_data  (pd),
            .prev_valid (pv),
            .next_data  (nd),
            .next_valid (nv),
            .data       (cell_data[i]),
            .valid      (cell_valid[i])
        );
    end

    assign head_data  = cell_data[0];
    assign head_valid = cell_valid[0];
    assign tail_valid = cell_valid[DEPTH-1];

endmodule

// ===== verif/deque_checker.sv =====
// Checker for double_ended_queue_core: watches both stream channels, keeps its own
// model of the deque and compares every result beat. Depends on deq_pkg.
module deque_checker
    import deq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,        // [31:0] value
    input  logic [1:0]  s_tuser,        // [1:0] kind
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,        // [31:0] front, [63:32] back, [68:64] count
    input  logic [1:0]  m_tuser,        // [1:0] status
    output int          fail_count,
    output int          views_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // What one result beat shows of the deque
    typedef struct packed {
        status_t      status;
        logic [31:0]  front_word;
        logic [31:0]  back_word;
        logic [4:0]   count;
    } deque_view_t;

    // Model state
    logic [31:0]  words [DEPTH];
    int           head_idx;
    int           tail_idx;
    int           fill;

    deque_view_t  views_due [$];
    int           mismatches = 0;

    task automatic report(input string msg);
        mismatches++;
        $display("%0t ns: %s", $time, msg);
    endtask

    // Apply one operation to the model and return the view after it
    task automatic deque_apply(input kind_t kind, input logic [31:0] word,
                               output deque_view_t view);
        status_t status;
        status = STAT_DONE;
        if (kind == KIND_PUSH_BACK || kind == KIND_PUSH_FRONT) begin
            if (fill >= DEPTH) begin
                status = STAT_FULL;
            end else if (fill == 0) begin
                // first word lands at the head slot, tail follows it
                words[head_idx] = word;
                tail_idx = head_idx;
                fill = 1;
            end else if (kind == KIND_PUSH_BACK) begin
                tail_idx = (tail_idx + 1) % DEPTH;
                words[tail_idx] = word;
                fill++;
            end else begin
                head_idx = (head_idx + DEPTH - 1) % DEPTH;
                words[head_idx] = word;
                fill++;
            end
        end else if (fill == 0) begin
            status = STAT_EMPTY;
        end else begin
            // pointers stay put when the last word leaves
            fill--;
            if (fill != 0) begin
                if (kind == KIND_POP_FRONT)
                    head_idx = (head_idx + 1) % DEPTH;
                else
                    tail_idx = (tail_idx + DEPTH - 1) % DEPTH;
            end
        end
        view.status     = status;
        view.front_word = (fill != 0) ? words[head_idx] : '0;
        view.back_word  = (fill != 0) ? words[tail_idx] : '0;
        view.count      = fill[4:0];
    endtask

    // Compare result beats first, then predict for the input beat of the same edge
    always @(posedge aclk) begin
        deque_view_t seen;
        deque_view_t want;
        if (!aresetn) begin
            head_idx = 0;
            tail_idx = 0;
            fill     = 0;
            views_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                seen.status     = status_t'(m_tuser);
                seen.front_word = m_tdata[31:0];
                seen.back_word  = m_tdata[63:32];
                seen.count      = m_tdata[68:64];
                if (views_due.size() == 0) begin
                    report($sformatf("result beat with nothing expected: %h %h", m_tuser,
                                     m_tdata));
                end else begin
                    want = views_due[0];
                    views_due.delete(0);
                    if (seen.status != want.status)
                        report($sformatf("status: got %0d, expected %0d",
                                         seen.status, want.status));
                    if (seen.front_word != want.front_word)
                        report($sformatf("front: got %h, expected %h",
                                         seen.front_word, want.front_word));
                    if (seen.back_word != want.back_word)
                        report($sformatf("back: got %h, expected %h",
                                         seen.back_word, want.back_word));
                    if (seen.count != want.count)
                        report($sformatf("count: got %0d, expected %0d",
                                         seen.count, want.count));
                end
            end
            if (s_tvalid && s_tready) begin
                deque_apply(kind_t'(s_tuser), s_tdata, want);
                views_due.insert(views_due.size(), want);
            end
        end
        views_pending <= views_due.size();
        fail_count    <= mismatches;
    end

endmodule

// ===== verif/tb.sv =====
// Top of the deque testbench: clock, reset, input and result-side stimulus,
// watchdog and verdict. Depends on deq_pkg, double_ended_queue_core, deque_checker.
module tb;
    import deq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 2000;
    localparam int RANDOM_OPS = 480;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [31:0]  s_tdata  = '0;
    logic [1:0]   s_tuser  = KIND_PUSH_BACK;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [71:0]  m_tdata;
    logic [1:0]   m_tuser;
    int           fail_count;
    int           views_pending;
    bit           sender_calm   = 1'b0;
    bit           receiver_calm = 1'b0;

    double_ended_queue_core #(.DEPTH(16)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    deque_checker #(.DEPTH(16)) u_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .views_pending (views_pending)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Send one beat after a random gap (none while the sender is calm), return at the edge that takes it
    task automatic send_op(input kind_t kind, input logic [31:0] word);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= word;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Hold the input side until every predicted result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (views_pending != 0);
    endtask

    // Result side: random stalls with calm stretches
    initial begin
        int stall;
        int run_left;
        run_left = 0;
        forever begin
            if (run_left == 0) begin
                run_left      = $urandom_range(4, 40);
                receiver_calm = ($urandom_range(0, 3) == 0);
            end
            run_left--;
            stall = receiver_calm ? 0 : $urandom_range(0, 18);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    // Watchdog on cycles without any beat
    initial begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle = 0;
            else
                idle++;
        end
        $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    // Input stimulus and verdict
    initial begin
        int           sent;
        int           seg_left;
        int           push_pct;
        bit           push;
        kind_t        kind;
        logic [31:0]  word;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // pops on empty, extremes, emptying by both ends
        send_op(KIND_POP_FRONT, 32'h1234_5678);
        send_op(KIND_POP_BACK, 32'hffff_ffff);
        send_op(KIND_PUSH_BACK, 32'h7fff_ffff);
        send_op(KIND_PUSH_FRONT, 32'h8000_0000);
        send_op(KIND_POP_BACK, 32'h0);
        send_op(KIND_POP_FRONT, 32'h0);

        // fill from both ends, then push on full at each end
        for (int i = 0; i < 16; i++) begin
            word = (i % 3 == 0) ? ~32'(i) : $urandom;
            send_op((i % 2 == 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK, word);
        end
        send_op(KIND_PUSH_BACK, 32'hdead_beef);
        send_op(KIND_PUSH_FRONT, 32'h0bad_f00d);
        drain_results();

        // random segments biased toward filling, emptying or balance
        sent     = 0;
        seg_left = 0;
        push_pct = 50;
        while (sent < RANDOM_OPS) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(8, 48);
                case ($urandom_range(0, 3))
                    0: begin
                        push_pct = 85;
                    end
                    1: begin
                        push_pct = 15;
                    end
                    default: begin
                        push_pct = 50;
                    end
                endcase
                sender_calm = ($urandom_range(0, 3) == 0);
            end
            push = ($urandom_range(0, 99) < push_pct);
            if (push)
                kind = ($urandom_range(0, 1) == 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
            else
                kind = ($urandom_range(0, 1) == 1) ? KIND_POP_BACK : KIND_POP_FRONT;
            case ($urandom_range(0, 9))
                0: begin
                    word = 32'h8000_0000;
                end
                1: begin
                    word = 32'h7fff_ffff;
                end
                default: begin
                    word = $urandom;
                end
            endcase
            send_op(kind, word);
            sent++;
            seg_left--;
            if (sent == RANDOM_OPS / 2)
                drain_results();
        end

        drain_results();
        repeat (4) @(posedge aclk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
